@@ rtl/core/gmc_pkg.sv @@
`timescale 1ns / 1ps
package gmc_pkg;

	// Default sizing of the grid and of the stored cell cost.
	localparam int GRID_MAX_DEF = 128;
	localparam int COST_BITS_DEF = 16;

	// Widths of the channel payloads.
	localparam int CELL_COST_W = 16;
	localparam int GRID_SIZE_W = 8;
	localparam int BUDGET_W = 31;
	localparam int CFG_IDX_W = 2;

	// Depth of the queue between the front and the back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_SIZE = 2'd0,
		CFG_BUDGET    = 2'd1
	} cfg_reg_t;

endpackage

@@ rtl/core/gmc_cell_if.sv @@
`timescale 1ns / 1ps
interface gmc_cell_if;
	logic                             valid;
	logic                             ready;
	logic [gmc_pkg::CELL_COST_W-1:0]  cell_cost;
	logic                             last_cell;

	modport source (output valid, output cell_cost, output last_cell, input ready);
	modport sink (input valid, input cell_cost, input last_cell, output ready);
endinterface

@@ rtl/core/gmc_res_if.sv @@
`timescale 1ns / 1ps
interface gmc_res_if;
	logic                          valid;
	logic                          ready;
	logic [gmc_pkg::BUDGET_W-1:0]  remaining;
	logic                          affordable;

	modport source (output valid, output remaining, output affordable, input ready);
	modport sink (input valid, input remaining, input affordable, output ready);
endinterface

@@ rtl/core/gmc_cfg_if.sv @@
`timescale 1ns / 1ps
interface gmc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [gmc_pkg::CFG_IDX_W-1:0] index;
	logic [gmc_pkg::BUDGET_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/gmc_front.sv @@
`timescale 1ns / 1ps
module gmc_front #(
	parameter int COST_BITS = gmc_pkg::COST_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gmc_cell_if.sink             cells,
	output logic                 item_valid,
	input  logic                 item_ready,
	output logic [COST_BITS-1:0] item_cost,
	output logic                 item_last
);
	import gmc_pkg::*;

	logic [COST_BITS-1:0]  cost_q [FIFO_DEPTH];
	logic                  last_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   cnt_q;
	logic                  push;
	logic                  pop;

	// The queue takes a transaction whenever it has room.
	assign cells.ready = (cnt_q != (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign push        = cells.valid && cells.ready;
	assign item_valid  = (cnt_q != '0);
	assign pop         = item_valid && item_ready;
	assign item_cost   = cost_q[rd_ptr_q];
	assign item_last   = last_q[rd_ptr_q];

	// Store the cost trimmed to the kept width, tagged with the last mark.
	always_ff @(posedge clk) begin
		if (push) begin
			cost_q[wr_ptr_q] <= COST_BITS'(cells.cell_cost);
			last_q[wr_ptr_q] <= cells.last_cell;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

@@ rtl/core/gmc_back.sv @@
`timescale 1ns / 1ps
module gmc_back #(
	parameter int GRID_MAX  = gmc_pkg::GRID_MAX_DEF,
	parameter int COST_BITS = gmc_pkg::COST_BITS_DEF,
	localparam int RW = $clog2(GRID_MAX + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [COST_BITS-1:0]          item_cost,
	input  logic                          item_last,
	input  logic [RW-1:0]                 n_in,
	input  logic [gmc_pkg::BUDGET_W-1:0]  budget,
	gmc_res_if.source                     result
);
	import gmc_pkg::*;

	localparam int CELLS = GRID_MAX * GRID_MAX;
	localparam int IDXW  = $clog2(CELLS);
	localparam int SUMW  = COST_BITS + IDXW;
	localparam int QW    = IDXW + 2 * RW;
	localparam int CW    = ((SUMW > BUDGET_W) ? SUMW : BUDGET_W) + 1;

	typedef enum logic [3:0] {
		ST_LOAD, ST_SIZE, ST_CLEAR, ST_SEED0, ST_SEED1, ST_POP, ST_POPW,
		ST_BEST, ST_NB, ST_NBR, ST_DONE, ST_FIN
	} state_t;

	typedef enum logic [1:0] {DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_LEFT} dir_t;

	// Memories.
	logic [COST_BITS-1:0] cost_mem [CELLS];
	logic [SUMW-1:0]      best_mem [CELLS];
	logic                 rch_mem  [CELLS];
	logic                 inq_mem  [CELLS];
	logic [QW-1:0]        q_mem    [CELLS];

	logic                 cost_we, best_we, rch_we, inq_we, q_we;
	logic [IDXW-1:0]      cost_wa, best_wa, rch_wa, inq_wa, q_wa;
	logic [IDXW-1:0]      cost_ra, best_ra, rch_ra, inq_ra, q_ra;
	logic [COST_BITS-1:0] cost_wd, cost_rd;
	logic [SUMW-1:0]      best_wd, best_rd;
	logic                 rch_wd, rch_rd, inq_wd, inq_rd;
	logic [QW-1:0]        q_wd, q_rd;

	// Control and working registers.
	state_t               state_q;
	logic [IDXW-1:0]      ld_q;
	logic [RW-1:0]        n_q;
	logic [IDXW:0]        total_q;
	logic [IDXW-1:0]      clr_q;
	logic [IDXW-1:0]      head_q, tail_q;
	logic [IDXW:0]        count_q;
	logic [IDXW-1:0]      p_q;
	logic [RW-1:0]        r_q, c_q;
	logic [SUMW-1:0]      best_p_q;
	dir_t                 k_q;
	logic [IDXW-1:0]      nbq_q;
	logic [RW-1:0]        nr_q, nc_q;
	logic                 res_valid_q;
	logic [BUDGET_W-1:0]  res_rem_q;
	logic                 res_aff_q;

	// Neighbor decode.
	logic                 nb_ok;
	logic [IDXW-1:0]      nb_idx;
	logic [RW-1:0]        nb_r, nb_c;
	logic [SUMW-1:0]      cand;
	logic                 upd;
	logic                 enq;
	logic [IDXW-1:0]      last_idx;
	logic [CW-1:0]        fin_cost, fin_budget;

	assign item_ready        = (state_q == ST_LOAD);
	assign result.valid      = res_valid_q;
	assign result.remaining  = res_rem_q;
	assign result.affordable = res_aff_q;
	assign last_idx          = IDXW'(total_q - 1'b1);
	assign cand              = best_p_q + SUMW'(cost_rd);
	assign upd               = !rch_rd || (cand < best_rd);
	assign enq               = upd && !inq_rd;
	assign fin_cost          = CW'(best_rd);
	assign fin_budget        = CW'(budget);

	// Position of the neighbor in the current direction and its bounds check.
	always_comb begin
		nb_ok  = 1'b0;
		nb_idx = p_q;
		nb_r   = r_q;
		nb_c   = c_q;
		case (k_q)
			DIR_UP: begin
				nb_ok  = (r_q != '0);
				nb_idx = p_q - IDXW'(n_q);
				nb_r   = r_q - 1'b1;
			end
			DIR_RIGHT: begin
				nb_ok  = ({1'b0, c_q} + 1'b1) < {1'b0, n_q};
				nb_idx = p_q + 1'b1;
				nb_c   = c_q + 1'b1;
			end
			DIR_DOWN: begin
				nb_ok  = ({1'b0, r_q} + 1'b1) < {1'b0, n_q};
				nb_idx = p_q + IDXW'(n_q);
				nb_r   = r_q + 1'b1;
			end
			DIR_LEFT: begin
				nb_ok  = (c_q != '0);
				nb_idx = p_q - 1'b1;
				nb_c   = c_q - 1'b1;
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	// Memory port control for each state.
	always_comb begin
		cost_we = 1'b0; cost_wa = ld_q; cost_wd = item_cost; cost_ra = nbq_q;
		best_we = 1'b0; best_wa = nbq_q; best_wd = cand; best_ra = nb_idx;
		rch_we  = 1'b0; rch_wa = nbq_q; rch_wd = 1'b1; rch_ra = nb_idx;
		inq_we  = 1'b0; inq_wa = nbq_q; inq_wd = 1'b1; inq_ra = nb_idx;
		q_we    = 1'b0; q_wa = tail_q; q_wd = {nbq_q, nr_q, nc_q}; q_ra = head_q;
		case (state_q)
			ST_LOAD: begin
				cost_we = item_valid;
			end
			ST_CLEAR: begin
				rch_we = 1'b1; rch_wa = clr_q; rch_wd = 1'b0;
				inq_we = 1'b1; inq_wa = clr_q; inq_wd = 1'b0;
			end
			ST_SEED0: begin
				cost_ra = '0;
			end
			ST_SEED1: begin
				best_we = 1'b1; best_wa = '0; best_wd = SUMW'(cost_rd);
				rch_we  = 1'b1; rch_wa = '0;
				inq_we  = 1'b1; inq_wa = '0;
				q_we    = 1'b1; q_wa = '0; q_wd = '0;
			end
			ST_POPW: begin
				inq_we  = 1'b1; inq_wa = q_rd[QW-1 -: IDXW]; inq_wd = 1'b0;
				best_ra = q_rd[QW-1 -: IDXW];
			end
			ST_NB: begin
				cost_ra = nb_idx;
			end
			ST_NBR: begin
				best_we = upd;
				rch_we  = upd;
				inq_we  = enq;
				q_we    = enq;
			end
			ST_DONE: begin
				best_ra = last_idx;
			end
			ST_FIN: begin
				// Keep the final cost on the read port while the result waits.
				best_ra = last_idx;
			end
			default: begin
				cost_we = 1'b0;
			end
		endcase
	end

	// Memory arrays with registered reads.
	always_ff @(posedge clk) begin
		if (cost_we) cost_mem[cost_wa] <= cost_wd;
		cost_rd <= cost_mem[cost_ra];
	end

	always_ff @(posedge clk) begin
		if (best_we) best_mem[best_wa] <= best_wd;
		best_rd <= best_mem[best_ra];
	end

	always_ff @(posedge clk) begin
		if (rch_we) rch_mem[rch_wa] <= rch_wd;
		rch_rd <= rch_mem[rch_ra];
	end

	always_ff @(posedge clk) begin
		if (inq_we) inq_mem[inq_wa] <= inq_wd;
		inq_rd <= inq_mem[inq_ra];
	end

	always_ff @(posedge clk) begin
		if (q_we) q_mem[q_wa] <= q_wd;
		q_rd <= q_mem[q_ra];
	end

	// Sequencer: load, clear the flags, relax from the ring, report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			ld_q        <= '0;
			n_q         <= RW'(1);
			total_q     <= (IDXW+1)'(1);
			clr_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			p_q         <= '0;
			r_q         <= '0;
			c_q         <= '0;
			best_p_q    <= '0;
			k_q         <= DIR_UP;
			nbq_q       <= '0;
			nr_q        <= '0;
			nc_q        <= '0;
			res_valid_q <= 1'b0;
			res_rem_q   <= '0;
			res_aff_q   <= 1'b0;
		end else begin
			if (res_valid_q && result.ready && state_q != ST_FIN) res_valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (item_valid) begin
						if (item_last) begin
							ld_q    <= '0;
							n_q     <= n_in;
							state_q <= ST_SIZE;
						end else if (ld_q == IDXW'(CELLS - 1)) begin
							ld_q <= '0;
						end else begin
							ld_q <= ld_q + 1'b1;
						end
					end
				end
				ST_SIZE: begin
					total_q <= (IDXW+1)'(n_q) * (IDXW+1)'(n_q);
					clr_q   <= '0;
					state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == last_idx) state_q <= ST_SEED0;
				end
				ST_SEED0: begin
					state_q <= ST_SEED1;
				end
				ST_SEED1: begin
					head_q  <= '0;
					tail_q  <= IDXW'(1);
					count_q <= (IDXW+1)'(1);
					state_q <= ST_POP;
				end
				ST_POP: begin
					state_q <= (count_q == '0) ? ST_DONE : ST_POPW;
				end
				ST_POPW: begin
					p_q     <= q_rd[QW-1 -: IDXW];
					r_q     <= q_rd[2*RW-1 -: RW];
					c_q     <= q_rd[RW-1:0];
					head_q  <= (head_q == IDXW'(CELLS - 1)) ? '0 : head_q + 1'b1;
					count_q <= count_q - 1'b1;
					state_q <= ST_BEST;
				end
				ST_BEST: begin
					best_p_q <= best_rd;
					k_q      <= DIR_UP;
					state_q  <= ST_NB;
				end
				ST_NB: begin
					if (nb_ok) begin
						nbq_q   <= nb_idx;
						nr_q    <= nb_r;
						nc_q    <= nb_c;
						state_q <= ST_NBR;
					end else if (k_q == DIR_LEFT) begin
						state_q <= ST_POP;
					end else begin
						k_q <= dir_t'(k_q + 1'b1);
					end
				end
				ST_NBR: begin
					if (enq) begin
						tail_q  <= (tail_q == IDXW'(CELLS - 1)) ? '0 : tail_q + 1'b1;
						count_q <= count_q + 1'b1;
					end
					if (k_q == DIR_LEFT) begin
						state_q <= ST_POP;
					end else begin
						k_q     <= dir_t'(k_q + 1'b1);
						state_q <= ST_NB;
					end
				end
				ST_DONE: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// Wait for the output register to be free.
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						res_aff_q   <= (fin_cost <= fin_budget);
						res_rem_q   <= (fin_cost <= fin_budget) ?
							BUDGET_W'(fin_budget - fin_cost) : '0;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end
endmodule

@@ rtl/core/grid_min_cost_path_budget_core.sv @@
`timescale 1ns / 1ps
// Cheapest grid path against a budget.
// The cells channel carries cell costs in row-major order, one transaction
// per cell; the transaction with last_cell set closes the grid and starts
// the search. The result channel then carries one transaction: remaining
// (budget minus the cheapest top-left to bottom-right path cost, both end
// cells counted, or zero when that cost exceeds the budget) and affordable.
// The cfg channel writes grid_size (index 0) and budget (index 1) and is
// always ready; write it only while idle. Cells load at one per cycle while
// the engine is loading, through a four-entry queue in front of the search
// engine. After the last cell the engine computes the size, clears its flag
// memories and seeds the work ring. Each cell taken from the ring is read,
// its best cost fetched, and each neighbor inside the grid relaxed in turn;
// the run length depends on the costs. The engine then finds the ring empty,
// reads the final cost and fills the output register. During the search no
// cells are taken beyond what the front queue holds.
// A stalled result sits in the output register; the next grid can load
// meanwhile, and its result waits until that register is free.
// Reset sets grid_size to 1, budget to 0, and empties both queues; cost
// memory contents are not cleared.
module grid_min_cost_path_budget_core #(
	parameter int GRID_MAX  = gmc_pkg::GRID_MAX_DEF,
	parameter int COST_BITS = gmc_pkg::COST_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gmc_cell_if.sink   cells,
	gmc_res_if.source  result,
	gmc_cfg_if.sink    cfg
);
	import gmc_pkg::*;

	localparam int RW = $clog2(GRID_MAX + 1);

	logic [GRID_SIZE_W-1:0] grid_size_q;
	logic [BUDGET_W-1:0]    budget_q;
	logic [RW-1:0]          n_eff;
	logic                   item_valid;
	logic                   item_ready;
	logic [COST_BITS-1:0]   item_cost;
	logic                   item_last;

	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_SIZE_W'(1);
			budget_q    <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_GRID_SIZE: grid_size_q <= cfg.data[GRID_SIZE_W-1:0];
				CFG_BUDGET:    budget_q    <= cfg.data;
				default:       budget_q    <= budget_q;
			endcase
		end
	end

	// Grid side in use: zero means one, large values saturate.
	always_comb begin
		if (grid_size_q == '0) begin
			n_eff = RW'(1);
		end else if (32'(grid_size_q) > GRID_MAX) begin
			n_eff = RW'(GRID_MAX);
		end else begin
			n_eff = RW'(grid_size_q);
		end
	end

	gmc_front #(
		.COST_BITS (COST_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cells      (cells),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_cost  (item_cost),
		.item_last  (item_last)
	);

	gmc_back #(
		.GRID_MAX  (GRID_MAX),
		.COST_BITS (COST_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_cost  (item_cost),
		.item_last  (item_last),
		.n_in       (n_eff),
		.budget     (budget_q),
		.result     (result)
	);
endmodule
